// ===== rtl/wss_pkg.sv =====
// Shared types and constants of the weighted 3x3 smoothing stencil.
`default_nettype none
package wss_pkg;

	localparam int MAX_SIDE_DEF   = 1024;
	localparam int PIXEL_BITS_DEF = 16;

	localparam int LEN_W    = 11;
	localparam int WEIGHT_W = 16;
	localparam int IDX_W    = 10;
	localparam int SMOOTH_W = 20;
	localparam int FRAC_W   = 16;

	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [LEN_W-1:0]    ROW_LENGTH_RST    = 11'd1024;
	localparam logic [WEIGHT_W-1:0] CORNER_WEIGHT_RST = 16'd3277;
	localparam logic [WEIGHT_W-1:0] EDGE_WEIGHT_RST   = 16'd6554;
	localparam logic [WEIGHT_W-1:0] CENTER_WEIGHT_RST = 16'd26214;

	typedef enum logic [1:0] {
		REG_ROW_LENGTH    = 2'd0,
		REG_CORNER_WEIGHT = 2'd1,
		REG_EDGE_WEIGHT   = 2'd2,
		REG_CENTER_WEIGHT = 2'd3
	} cfg_reg_t;

	// position and frame marker that ride along with a result
	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last;
	} tag_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] corner;
		logic [WEIGHT_W-1:0] edge_w;
		logic [WEIGHT_W-1:0] center;
	} weights_t;

endpackage
`default_nettype wire

// ===== rtl/weighted_3x3_smoothing_stencil.sv =====
// A result passes stage 1, stage 2, the s3 and s4 weighting stages and the output register.
// Throughput: one pixel per cycle; the whole pipeline holds while a result waits on m_tready.
// Line store: read on accept, written from stage 1, so its read register sets the front stage.
// Reset clears position counters, window cells, valid bits and loads the register defaults.
// Line store contents are not cleared and there is no clearing pass.
`default_nettype none
module weighted_3x3_smoothing_stencil #(
	parameter int MAX_SIDE   = wss_pkg::MAX_SIDE_DEF,
	parameter int PIXEL_BITS = wss_pkg::PIXEL_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// APB configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [wss_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [wss_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [wss_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                pready,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((PIXEL_BITS+7)/8)*8-1:0]     s_tdata,  // pixel
	input  logic                                s_tuser,  // frame_start
	// output stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [39:0]                         m_tdata,  // smoothed, out_row, out_col
	output logic                                m_tlast   // frame_done
);

	import wss_pkg::*;

	localparam int CW = $clog2(MAX_SIDE);
	localparam int NW = $clog2(MAX_SIDE + 1);
	localparam int LW = (NW > LEN_W) ? NW : LEN_W;
	localparam int EW = 2 * PIXEL_BITS;
	localparam logic [LW-1:0] MIN_SIDE_L = LW'(3);
	localparam logic [LW-1:0] MAX_SIDE_L = LW'(MAX_SIDE);

	// configuration registers
	logic [LEN_W-1:0]    row_length_q;
	logic [WEIGHT_W-1:0] corner_weight_q;
	logic [WEIGHT_W-1:0] edge_weight_q;
	logic [WEIGHT_W-1:0] center_weight_q;
	cfg_reg_t            cfg_sel;
	logic                cfg_we;

	assign pready  = 1'b1;
	assign cfg_sel = cfg_reg_t'(paddr[3:2]);
	assign cfg_we  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q    <= ROW_LENGTH_RST;
			corner_weight_q <= CORNER_WEIGHT_RST;
			edge_weight_q   <= EDGE_WEIGHT_RST;
			center_weight_q <= CENTER_WEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_sel)
				REG_ROW_LENGTH:    row_length_q    <= pwdata[LEN_W-1:0];
				REG_CORNER_WEIGHT: corner_weight_q <= pwdata[WEIGHT_W-1:0];
				REG_EDGE_WEIGHT:   edge_weight_q   <= pwdata[WEIGHT_W-1:0];
				REG_CENTER_WEIGHT: center_weight_q <= pwdata[WEIGHT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			REG_ROW_LENGTH:    prdata = CFG_DATA_W'(row_length_q);
			REG_CORNER_WEIGHT: prdata = CFG_DATA_W'(corner_weight_q);
			REG_EDGE_WEIGHT:   prdata = CFG_DATA_W'(edge_weight_q);
			REG_CENTER_WEIGHT: prdata = CFG_DATA_W'(center_weight_q);
		endcase
	end

	// pipeline enable: advance unless a result is held at the output
	logic en;
	logic accept;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign accept   = s_tvalid && s_tready;

	// side in use, clamped to the supported range
	logic [LW-1:0] len_ext;
	logic [LW-1:0] len_clamp;
	logic [NW-1:0] side;

	assign len_ext = LW'(row_length_q);

	always_comb begin
		priority if (len_ext < MIN_SIDE_L) begin
			len_clamp = MIN_SIDE_L;
		end else if (len_ext > MAX_SIDE_L) begin
			len_clamp = MAX_SIDE_L;
		end else begin
			len_clamp = len_ext;
		end
	end

	assign side = NW'(len_clamp);

	// position of the incoming pixel
	logic [CW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [NW-1:0] row_b;
	logic [NW-1:0] col_b;
	logic [NW-1:0] row_c;
	logic [NW-1:0] col_c;
	logic [NW-1:0] col_nx;
	logic [NW-1:0] row_nx;
	logic          emit;
	logic          last;

	always_comb begin
		row_b = s_tuser ? '0 : NW'(row_q);
		col_b = s_tuser ? '0 : NW'(col_q);
		row_c = row_b;
		col_c = col_b;
		// wrap a position left outside a shortened side
		if (col_b >= side) begin
			col_c = '0;
			row_c = row_b + 1'b1;
		end
		if (row_c >= side) begin
			row_c = '0;
		end
		col_nx = col_c + 1'b1;
		row_nx = row_c + 1'b1;
		emit   = (row_c >= NW'(2)) && (col_c >= NW'(2));
		last   = (row_c == side - 1'b1) && (col_c == side - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_nx >= side) begin
				col_q <= '0;
				row_q <= (row_nx >= side) ? '0 : CW'(row_nx);
			end else begin
				col_q <= CW'(col_nx);
				row_q <= CW'(row_c);
			end
		end
	end

	// stage 1: line store read in flight
	logic                  v_s1;
	logic                  emit_s1;
	tag_t                  tag_s1;
	logic [CW-1:0]         addr_s1;
	logic [PIXEL_BITS-1:0] px_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			emit_s1     <= emit;
			tag_s1.row  <= IDX_W'(row_c - 1'b1);
			tag_s1.col  <= IDX_W'(col_c - 1'b1);
			tag_s1.last <= last;
			addr_s1     <= CW'(col_c);
			px_s1       <= s_tdata[PIXEL_BITS-1:0];
		end
	end

	// line store entry: upper row in the high half, middle row in the low half
	logic [EW-1:0] line_rd;
	logic          shift;

	assign shift = en && v_s1;

	wss_line_store #(
		.DEPTH (MAX_SIDE),
		.WIDTH (EW)
	) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.rd_addr (CW'(col_c)),
		.wr_en   (shift),
		.wr_addr (addr_s1),
		.wr_data ({line_rd[PIXEL_BITS-1:0], px_s1}),
		.rd_data (line_rd)
	);

	// window: cell 0 holds the newest column, cell 2 the oldest
	logic [PIXEL_BITS-1:0] c_up   [3];
	logic [PIXEL_BITS-1:0] c_mid  [3];
	logic [PIXEL_BITS-1:0] c_px   [3];
	logic [PIXEL_BITS:0]   c_ends [3];

	wss_cell #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_cell0 (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (shift),
		.up_in  (line_rd[EW-1:PIXEL_BITS]),
		.mid_in (line_rd[PIXEL_BITS-1:0]),
		.px_in  (px_s1),
		.up     (c_up[0]),
		.mid    (c_mid[0]),
		.px     (c_px[0]),
		.ends   (c_ends[0])
	);

	for (genvar i = 1; i < 3; i++) begin : g_cell
		wss_cell #(
			.PIXEL_BITS (PIXEL_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.up_in  (c_up[i-1]),
			.mid_in (c_mid[i-1]),
			.px_in  (c_px[i-1]),
			.up     (c_up[i]),
			.mid    (c_mid[i]),
			.px     (c_px[i]),
			.ends   (c_ends[i])
		);
	end

	// stage 2: window holds this item's neighborhood
	logic                  v_s2;
	tag_t                  tag_s2;
	logic [PIXEL_BITS+1:0] diag;
	logic [PIXEL_BITS+1:0] orth;
	weights_t              weights;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s2 <= tag_s1;
		end
	end

	assign diag = (PIXEL_BITS+2)'(c_ends[0]) + (PIXEL_BITS+2)'(c_ends[2]);
	assign orth = (PIXEL_BITS+2)'(c_ends[1]) + (PIXEL_BITS+2)'(c_mid[0])
		+ (PIXEL_BITS+2)'(c_mid[2]);

	assign weights.corner = corner_weight_q;
	assign weights.edge_w = edge_weight_q;
	assign weights.center = center_weight_q;

	logic                mac_valid;
	tag_t                mac_tag;
	logic [SMOOTH_W-1:0] mac_result;

	wss_mac #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.tag_in    (tag_s2),
		.diag      (diag),
		.orth      (orth),
		.ctr       (c_mid[1]),
		.weights   (weights),
		.out_valid (mac_valid),
		.tag_out   (mac_tag),
		.result    (mac_result)
	);

	// output register
	logic                m_valid_q;
	logic [SMOOTH_W-1:0] smoothed_q;
	tag_t                tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (en) begin
			m_valid_q <= mac_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			smoothed_q <= mac_result;
			tag_q      <= mac_tag;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {tag_q.col, tag_q.row, smoothed_q};
	assign m_tlast  = tag_q.last;

endmodule
`default_nettype wire

// ===== rtl/wss_line_store.sv =====
// Combined two-row line store with registered read and write-to-read bypass.
`default_nettype none
module wss_line_store #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	output logic [WIDTH-1:0]         rd_data
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;
	logic [AW-1:0]    rd_addr_q;
	logic             byp_v_q;
	logic [AW-1:0]    byp_addr_q;
	logic [WIDTH-1:0] byp_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (en) begin
			rd_q      <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
		if (wr_en) begin
			byp_addr_q <= wr_addr;
			byp_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_v_q <= 1'b0;
		end else if (wr_en) begin
			byp_v_q <= 1'b1;
		end
	end

	// a write on the same edge as the read is missed by the array: take it from the bypass
	assign rd_data = (byp_v_q && byp_addr_q == rd_addr_q) ? byp_data_q : rd_q;

endmodule
`default_nettype wire

// ===== rtl/wss_cell.sv =====
// One window column cell: holds three vertical pixels and passes them to its neighbor.
`default_nettype none
module wss_cell #(
	parameter int PIXEL_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift,
	input  logic [PIXEL_BITS-1:0] up_in,
	input  logic [PIXEL_BITS-1:0] mid_in,
	input  logic [PIXEL_BITS-1:0] px_in,
	output logic [PIXEL_BITS-1:0] up,
	output logic [PIXEL_BITS-1:0] mid,
	output logic [PIXEL_BITS-1:0] px,
	output logic [PIXEL_BITS:0]   ends
);

	logic [PIXEL_BITS-1:0] up_q;
	logic [PIXEL_BITS-1:0] mid_q;
	logic [PIXEL_BITS-1:0] px_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q  <= '0;
			mid_q <= '0;
			px_q  <= '0;
		end else if (shift) begin
			up_q  <= up_in;
			mid_q <= mid_in;
			px_q  <= px_in;
		end
	end

	assign up   = up_q;
	assign mid  = mid_q;
	assign px   = px_q;
	// top plus bottom of the column: diagonal terms at the outer cells, orthogonal at the middle
	assign ends = {1'b0, up_q} + {1'b0, px_q};

endmodule
`default_nettype wire

// ===== rtl/wss_mac.sv =====
// Weighting pipeline: register the window sums, multiply by the weights, add and truncate.
`default_nettype none
module wss_mac #(
	parameter int PIXEL_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  wss_pkg::tag_t                 tag_in,
	input  logic [PIXEL_BITS+1:0]         diag,
	input  logic [PIXEL_BITS+1:0]         orth,
	input  logic [PIXEL_BITS-1:0]         ctr,
	input  wss_pkg::weights_t             weights,
	output logic                          out_valid,
	output wss_pkg::tag_t                 tag_out,
	output logic [wss_pkg::SMOOTH_W-1:0]  result
);

	import wss_pkg::*;

	localparam int SUM_W  = PIXEL_BITS + 2;
	localparam int PROD_W = SUM_W + WEIGHT_W;
	localparam int ACC_W  = PROD_W + 2;

	logic                  v_s3;
	logic                  v_s4;
	tag_t                  tag_s3;
	tag_t                  tag_s4;
	logic [SUM_W-1:0]      diag_s3;
	logic [SUM_W-1:0]      orth_s3;
	logic [PIXEL_BITS-1:0] ctr_s3;
	logic [PROD_W-1:0]     pdiag_s4;
	logic [PROD_W-1:0]     porth_s4;
	logic [PROD_W-1:0]     pctr_s4;
	logic [ACC_W-1:0]      acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= in_valid;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s3   <= tag_in;
			diag_s3  <= diag;
			orth_s3  <= orth;
			ctr_s3   <= ctr;
			tag_s4   <= tag_s3;
			pdiag_s4 <= diag_s3 * weights.corner;
			porth_s4 <= orth_s3 * weights.edge_w;
			pctr_s4  <= PROD_W'(ctr_s3 * weights.center);
		end
	end

	assign acc = ACC_W'(pdiag_s4) + ACC_W'(porth_s4) + ACC_W'(pctr_s4);

	assign out_valid = v_s4;
	assign tag_out   = tag_s4;
	assign result    = SMOOTH_W'(acc >> FRAC_W);

endmodule
`default_nettype wire

// ===== tb/weighted_3x3_smoothing_stencil_tb.sv =====
// Self-checking testbench for the weighted 3x3 smoothing stencil: stream stimulus, predicted results.
module weighted_3x3_smoothing_stencil_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wss_pkg::*;

	localparam int PIX_W         = 16;
	localparam int ROW_LSB       = SMOOTH_W;
	localparam int COL_LSB       = SMOOTH_W + IDX_W;
	localparam int IDLE_PCT      = 11;
	localparam int SETTLE_CYCLES = 12;
	localparam int STALL_LIMIT   = 1000;
	localparam int FIRST_SIDE    = 12;
	localparam int RANDOM_ITEMS  = 650;

	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic             start;
	} pixel_word_t;

	typedef struct {
		logic [SMOOTH_W-1:0] value;
		tag_t                tag;
	} smoothed_word_t;

	typedef enum {FILL_RANDOM, FILL_MAX, FILL_ZERO, FILL_CHECKER} fill_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr    = '0;
	logic [CFG_DATA_W-1:0] pwdata   = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata  = '0;
	logic                  s_tuser  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [39:0]           m_tdata;
	logic                  m_tlast;

	pixel_word_t    pixel_feed[$];
	smoothed_word_t expected_results[$];
	int             mismatch_count = 0;
	bit             steady = 1'b0;

	// shadow of the filter: registers, line stores, window, position
	logic [LEN_W-1:0]    row_length_reg = ROW_LENGTH_RST;
	logic [WEIGHT_W-1:0] diag_w         = CORNER_WEIGHT_RST;
	logic [WEIGHT_W-1:0] orth_w         = EDGE_WEIGHT_RST;
	logic [WEIGHT_W-1:0] center_w       = CENTER_WEIGHT_RST;
	bit [PIX_W-1:0]      upper_row_store[MAX_SIDE_DEF];
	bit [PIX_W-1:0]      middle_row_store[MAX_SIDE_DEF];
	bit [PIX_W-1:0]      win[9];
	int                  row_pos = 0;
	int                  col_pos = 0;

	weighted_3x3_smoothing_stencil i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	function automatic int clamp_side(input logic [LEN_W-1:0] len);
		if (len < 3) return 3;
		if (len > MAX_SIDE_DEF) return MAX_SIDE_DEF;
		return int'(len);
	endfunction

	function automatic logic [PIX_W-1:0] draw_pixel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	function automatic logic [WEIGHT_W-1:0] draw_weight();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return WEIGHT_W'($urandom);
		endcase
	endfunction

	task automatic flag_mismatch(input string what);
		$display("%0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	// advance the shadow filter by one pixel and queue the result it completes
	task automatic advance_stencil(input logic [PIX_W-1:0] px, input logic start);
		int             side, r, c;
		bit [PIX_W-1:0] up, mid;
		bit [39:0]      diag, orth, acc;
		smoothed_word_t res;
		side = clamp_side(row_length_reg);
		if (start) begin
			row_pos = 0;
			col_pos = 0;
		end
		// wrap a position left outside a shorter side
		if (col_pos >= side) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= side) row_pos = 0;
		r = row_pos;
		c = col_pos;
		up = upper_row_store[c];
		mid = middle_row_store[c];
		upper_row_store[c] = mid;
		middle_row_store[c] = px;
		win[0] = win[1]; win[1] = win[2]; win[2] = up;
		win[3] = win[4]; win[4] = win[5]; win[5] = mid;
		win[6] = win[7]; win[7] = win[8]; win[8] = px;
		if (r >= 2 && c >= 2) begin
			diag = 40'(win[0]) + win[2] + win[6] + win[8];
			orth = 40'(win[1]) + win[3] + win[5] + win[7];
			acc = diag * diag_w + orth * orth_w + 40'(win[4]) * center_w;
			res.value = SMOOTH_W'(acc >> FRAC_W);
			res.tag.row = IDX_W'(r - 1);
			res.tag.col = IDX_W'(c - 1);
			res.tag.last = (r == side - 1) && (c == side - 1);
			expected_results.push_back(res);
		end
		col_pos = c + 1;
		if (col_pos >= side) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= side) row_pos = 0;
		end
	endtask

	// write one register with junk in the unused bits, then read it back
	task automatic set_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		logic [CFG_DATA_W-1:0] noisy, stored, readback;
		noisy = $urandom;
		if (idx == REG_ROW_LENGTH) begin
			noisy[LEN_W-1:0] = value[LEN_W-1:0];
			stored = CFG_DATA_W'(value[LEN_W-1:0]);
		end else begin
			noisy[WEIGHT_W-1:0] = value[WEIGHT_W-1:0];
			stored = CFG_DATA_W'(value[WEIGHT_W-1:0]);
		end
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'({idx, 2'b00});
		pwdata <= noisy;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_ROW_LENGTH:    row_length_reg = stored[LEN_W-1:0];
			REG_CORNER_WEIGHT: diag_w = stored[WEIGHT_W-1:0];
			REG_EDGE_WEIGHT:   orth_w = stored[WEIGHT_W-1:0];
			REG_CENTER_WEIGHT: center_w = stored[WEIGHT_W-1:0];
		endcase
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback !== stored)
			flag_mismatch($sformatf("register %s reads %0h, wrote %0h",
				idx.name(), readback, stored));
	endtask

	// read one register and compare it with the value it should hold
	task automatic check_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] want);
		logic [CFG_DATA_W-1:0] readback;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= CFG_ADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback !== want)
			flag_mismatch($sformatf("register %s reads %0h after reset, want %0h",
				idx.name(), readback, want));
	endtask

	task automatic program_filter(input logic [LEN_W-1:0] len, input logic [WEIGHT_W-1:0] cw,
			input logic [WEIGHT_W-1:0] ew, input logic [WEIGHT_W-1:0] xw);
		set_register(REG_ROW_LENGTH, CFG_DATA_W'(len));
		set_register(REG_CORNER_WEIGHT, CFG_DATA_W'(cw));
		set_register(REG_EDGE_WEIGHT, CFG_DATA_W'(ew));
		set_register(REG_CENTER_WEIGHT, CFG_DATA_W'(xw));
	endtask

	task automatic feed(input int count, input bit first_start, input int stray_pct,
			input fill_t fill);
		pixel_word_t w;
		@(negedge clk);
		for (int i = 0; i < count; i++) begin
			case (fill)
				FILL_MAX:     w.pixel = '1;
				FILL_ZERO:    w.pixel = '0;
				FILL_CHECKER: w.pixel = (i % 2 == 0) ? '1 : '0;
				default:      w.pixel = draw_pixel();
			endcase
			w.start = (i == 0) ? first_start : ($urandom_range(99) < stray_pct);
			pixel_feed.push_back(w);
		end
	endtask

	// wait until every word is taken and every result is back, then let the pipe empty
	task automatic settle();
		@(negedge clk);
		while (pixel_feed.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	always @(posedge clk) begin : drive_pixels
		pixel_word_t word;
		if (arst_n) begin
			if (s_tvalid && s_tready) advance_stencil(s_tdata, s_tuser);
			if (!s_tvalid || s_tready) begin
				if (pixel_feed.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					word = pixel_feed.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= word.pixel;
					s_tuser <= word.start;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		smoothed_word_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected result %0d at row %0d col %0d",
						m_tdata[SMOOTH_W-1:0], m_tdata[ROW_LSB +: IDX_W],
						m_tdata[COL_LSB +: IDX_W]));
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[SMOOTH_W-1:0] !== want.value)
						flag_mismatch($sformatf("smoothed %0d, want %0d at row %0d col %0d",
							m_tdata[SMOOTH_W-1:0], want.value, want.tag.row, want.tag.col));
					if (m_tdata[ROW_LSB +: IDX_W] !== want.tag.row)
						flag_mismatch($sformatf("out_row %0d, want %0d",
							m_tdata[ROW_LSB +: IDX_W], want.tag.row));
					if (m_tdata[COL_LSB +: IDX_W] !== want.tag.col)
						flag_mismatch($sformatf("out_col %0d, want %0d",
							m_tdata[COL_LSB +: IDX_W], want.tag.col));
					if (m_tlast !== want.tag.last)
						flag_mismatch($sformatf("frame_done %b, want %b at row %0d col %0d",
							m_tlast, want.tag.last, want.tag.row, want.tag.col));
				end
			end
			m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		int               pick, side, count, fed;
		bit               restart;
		logic [LEN_W-1:0] len;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset values read back, then the default weights on a whole frame with no stalls
		check_register(REG_ROW_LENGTH, CFG_DATA_W'(ROW_LENGTH_RST));
		check_register(REG_CORNER_WEIGHT, CFG_DATA_W'(CORNER_WEIGHT_RST));
		check_register(REG_EDGE_WEIGHT, CFG_DATA_W'(EDGE_WEIGHT_RST));
		check_register(REG_CENTER_WEIGHT, CFG_DATA_W'(CENTER_WEIGHT_RST));
		set_register(REG_ROW_LENGTH, CFG_DATA_W'(FIRST_SIDE));
		@(negedge clk);
		steady = 1'b1;
		feed(FIRST_SIDE * FIRST_SIDE, 1'b1, 0, FILL_RANDOM);
		settle();
		steady = 1'b0;

		// smallest side written as zero, every weight and pixel at full scale
		program_filter(11'd0, '1, '1, '1);
		feed(9, 1'b1, 0, FILL_MAX);
		settle();

		// side below range; frame wraps without a start, then a start lands mid-frame
		program_filter(11'd2, '0, '1, 16'd1);
		feed(9, 1'b0, 0, FILL_CHECKER);
		feed(4, 1'b1, 0, FILL_CHECKER);
		feed(9, 1'b1, 0, FILL_RANDOM);
		settle();

		// side above range, then shrink mid-frame: column wrap, then row wrap
		program_filter(11'd2047, draw_weight(), draw_weight(), draw_weight());
		feed(6, 1'b1, 0, FILL_RANDOM);
		settle();
		program_filter(11'd4, draw_weight(), draw_weight(), draw_weight());
		feed(10, 1'b0, 0, FILL_RANDOM);
		settle();
		program_filter(11'd3, draw_weight(), draw_weight(), draw_weight());
		feed(7, 1'b0, 0, FILL_RANDOM);
		settle();

		fed = 0;
		while (fed < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 70) len = LEN_W'($urandom_range(3, 8));
			else if (pick < 85) len = LEN_W'($urandom_range(9, 12));
			else if (pick < 93) len = LEN_W'($urandom_range(0, 2));
			else if ($urandom_range(1)) len = LEN_W'(MAX_SIDE_DEF);
			else len = LEN_W'($urandom_range(MAX_SIDE_DEF + 1, 2047));
			side = clamp_side(len);
			// a wider side needs fresh rows in the line stores before any result
			restart = (side > clamp_side(row_length_reg)) || ($urandom_range(99) < 70);
			program_filter(len, draw_weight(), draw_weight(), draw_weight());
			if (side >= MAX_SIDE_DEF) begin
				count = $urandom_range(20, 60);
			end else begin
				count = side * side * $urandom_range(1, 2);
				if ($urandom_range(99) < 25) count = $urandom_range(1, count);
			end
			feed(count, restart, 2, FILL_RANDOM);
			fed += count;
			settle();
		end

		if (mismatch_count == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule
